### rtl/packbits_style_rle_encoder_core_defines.svh
// Assertion macros for the PackBits-style RLE encoder core.
`ifndef PACKBITS_STYLE_RLE_ENCODER_CORE_DEFINES_SVH
`define PACKBITS_STYLE_RLE_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define PBRLE_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// when ante holds, cons must hold in the same cycle
`define PBRLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PBRLE_ASSERT(label, clk, rst_n, cond, msg)
`define PBRLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/pbrle_pkg.sv
// Shared types and constants of the PackBits-style RLE encoder.
`default_nettype none

package pbrle_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int TOK_W   = 9;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef enum logic {
        CMD_RUN,
        CMD_LIT
    } t_cmd_kind;

    // one token to emit: repeat (count + byte) or literal (count + stored bytes)
    typedef struct packed {
        t_cmd_kind          kind;
        logic [CNT_W-1:0]   count;
        logic [BYTE_W-1:0]  data;
        logic               burst_end;
        logic               stream_end;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_COUNT,
        BK_RUN_BYTE,
        BK_LIT_BYTE
    } t_back_state;

endpackage

`default_nettype wire

### rtl/packbits_style_rle_encoder_core.sv
// Top level of the PackBits-style RLE encoder core.
//
// Input channel: one byte per transaction on i_data_byte, with i_final_byte set
// on the last byte of a string; taken when push is high and full is low.
// Result channel: count items (o_is_count=1, o_token_count > 0 for a repeat,
// < 0 for a literal) each followed by its data items on o_out_byte; the head
// item is shown while empty is low and taken when pop is high.
// o_burst_end marks the last result of one input transaction, o_stream_end
// the last result of the string.
// A token passes the token queue, the back end's command register and result register.
// Throughput: one byte per cycle while the queue and hold register have room and
// no literal group drains. A repeat token yields a count and one data item, a
// literal group of n bytes a count and n data items; full stays high while it
// drains. Two tokens from one transaction hold full high while the second waits.
// Reset (synchronous, i_rst_n low) drops queued tokens and the pending result and
// returns to the start of a string.
// When pop stays low the result register and the token queue fill, and full rises.
`default_nettype none

module packbits_style_rle_encoder_core #(
    parameter int MAX_LITERAL = 32,
    parameter int MAX_RUN     = 255
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 push,
    output logic                                full,
    input  wire  [pbrle_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire                                 i_final_byte,
    output logic                                empty,
    input  wire                                 pop,
    output logic                                o_is_count,
    output logic signed [pbrle_pkg::TOK_W-1:0]  o_token_count,
    output logic [pbrle_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                                o_burst_end,
    output logic                                o_stream_end
);
    import pbrle_pkg::*;

    localparam int IW = $clog2(MAX_LITERAL);

    logic              q_push, q_pop, q_empty, q_full;
    t_cmd              q_in_cmd, q_out_cmd;
    logic              lit_done;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] lit_first;

    pbrle_front #(
        .MAX_LITERAL (MAX_LITERAL),
        .MAX_RUN     (MAX_RUN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd),
        .i_q_full     (q_full),
        .i_lit_done   (lit_done),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_lit_first  (lit_first)
    );

    pbrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pbrle_back #(
        .MAX_LITERAL (MAX_LITERAL)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_cmd       (q_out_cmd),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_data     (wr_data),
        .i_lit_first   (lit_first),
        .o_lit_done    (lit_done),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_is_count    (o_is_count),
        .o_token_count (o_token_count),
        .o_out_byte    (o_out_byte),
        .o_burst_end   (o_burst_end),
        .o_stream_end  (o_stream_end)
    );

endmodule

`default_nettype wire

### rtl/pbrle_queue.sv
// Short token command queue between the front and back ends.
`default_nettype none

module pbrle_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  pbrle_pkg::t_cmd    i_cmd,
    input  wire                i_pop,
    output pbrle_pkg::t_cmd    o_cmd,
    output logic               o_empty,
    output logic               o_full
);
    import pbrle_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_count, n_count;
    logic               do_push, do_pop;

    always_comb begin
        o_empty  = (r_count == '0);
        o_full   = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = do_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + (Q_PTR_W+1)'(1);
            2'b01:   n_count = r_count - (Q_PTR_W+1)'(1);
            default: n_count = r_count;
        endcase
        o_cmd = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/pbrle_front.sv
// Front end: accepts bytes, tracks run/literal state, queues token commands.
`default_nettype none
`include "packbits_style_rle_encoder_core_defines.svh"

module pbrle_front #(
    parameter int MAX_LITERAL = 32,
    parameter int MAX_RUN     = 255,
    localparam int IW         = $clog2(MAX_LITERAL)
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    output logic                          o_full,
    input  wire  [pbrle_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire                           i_final_byte,
    output logic                          o_q_push,
    output pbrle_pkg::t_cmd               o_q_cmd,
    input  wire                           i_q_full,
    input  wire                           i_lit_done,
    output logic                          o_wr_en,
    output logic [IW-1:0]                 o_wr_addr,
    output logic [pbrle_pkg::BYTE_W-1:0]  o_wr_data,
    output logic [pbrle_pkg::BYTE_W-1:0]  o_lit_first
);
    import pbrle_pkg::*;

    localparam int LW = $clog2(MAX_LITERAL + 1);

    logic [BYTE_W-1:0] r_prev, n_prev;
    logic              r_have, n_have;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [LW-1:0]     r_lit_len, n_lit_len;
    logic              r_in_lit, n_in_lit;
    logic [BYTE_W-1:0] r_first, n_first;
    logic              r_busy, n_busy;
    logic              r_hold_valid, n_hold_valid;
    t_cmd              r_hold, n_hold;
    logic              accept;
    logic              cmd0_v, cmd1_v;
    t_cmd              cmd0, cmd1;

    function automatic t_cmd make_cmd(t_cmd_kind kind, logic [CNT_W-1:0] count,
                                      logic [BYTE_W-1:0] data, logic be, logic se);
        t_cmd c;
        c.kind       = kind;
        c.count      = count;
        c.data       = data;
        c.burst_end  = be;
        c.stream_end = se;
        return c;
    endfunction

    always_comb begin
        o_full       = i_q_full || r_hold_valid || r_busy;
        accept       = i_push && !o_full;
        n_prev       = r_prev;
        n_have       = r_have;
        n_run        = r_run;
        n_lit_len    = r_lit_len;
        n_in_lit     = r_in_lit;
        n_first      = r_first;
        cmd0_v       = 1'b0;
        cmd1_v       = 1'b0;
        cmd0         = make_cmd(CMD_RUN, '0, '0, 1'b0, 1'b0);
        cmd1         = cmd0;
        o_wr_en      = 1'b0;
        o_wr_addr    = '0;
        o_wr_data    = i_data_byte;

        if (accept) begin
            if (!r_have) begin
                n_have    = 1'b1;
                n_in_lit  = 1'b0;
                n_run     = CNT_W'(1);
                n_lit_len = '0;
            end else if (!r_in_lit) begin
                if (i_data_byte == r_prev) begin
                    if (r_run >= CNT_W'(MAX_RUN)) begin
                        cmd0_v = 1'b1;
                        cmd0   = make_cmd(CMD_RUN, CNT_W'(MAX_RUN), r_prev, !i_final_byte, 1'b0);
                        n_run  = CNT_W'(1);
                    end else begin
                        n_run = r_run + CNT_W'(1);
                    end
                end else if (r_run >= CNT_W'(2)) begin
                    cmd0_v = 1'b1;
                    cmd0   = make_cmd(CMD_RUN, r_run, r_prev, !i_final_byte, 1'b0);
                    n_run  = CNT_W'(1);
                end else begin
                    // two differing bytes open a literal group; entry 0 lives in r_first
                    n_first   = r_prev;
                    o_wr_en   = 1'b1;
                    o_wr_addr = IW'(1);
                    n_lit_len = LW'(2);
                    n_in_lit  = 1'b1;
                    n_run     = '0;
                end
            end else begin
                if (i_data_byte == r_prev) begin
                    // last literal byte moves into a run of two
                    cmd0_v    = 1'b1;
                    cmd0      = make_cmd(CMD_LIT, CNT_W'(r_lit_len) - CNT_W'(1), '0,
                                         !i_final_byte, 1'b0);
                    n_in_lit  = 1'b0;
                    n_lit_len = '0;
                    n_run     = CNT_W'(2);
                end else if (r_lit_len >= LW'(MAX_LITERAL)) begin
                    cmd0_v    = 1'b1;
                    cmd0      = make_cmd(CMD_LIT, CNT_W'(r_lit_len), '0, !i_final_byte, 1'b0);
                    n_in_lit  = 1'b0;
                    n_lit_len = '0;
                    n_run     = CNT_W'(1);
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_lit_len[IW-1:0];
                    n_lit_len = r_lit_len + LW'(1);
                end
            end
            n_prev = i_data_byte;

            if (i_final_byte) begin
                cmd1_v = 1'b1;
                if (n_in_lit) begin
                    cmd1 = make_cmd(CMD_LIT, CNT_W'(n_lit_len), '0, 1'b1, 1'b1);
                end else begin
                    cmd1 = make_cmd(CMD_RUN, n_run, i_data_byte, 1'b1, 1'b1);
                end
                n_prev    = '0;
                n_have    = 1'b0;
                n_run     = '0;
                n_lit_len = '0;
                n_in_lit  = 1'b0;
            end
        end

        // a second token from one transaction waits in the hold register
        o_q_push     = 1'b0;
        o_q_cmd      = cmd0;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        if (r_hold_valid) begin
            o_q_push     = !i_q_full;
            o_q_cmd      = r_hold;
            n_hold_valid = i_q_full;
        end else if (cmd0_v) begin
            o_q_push     = 1'b1;
            o_q_cmd      = cmd0;
            n_hold_valid = cmd1_v;
            n_hold       = cmd1;
        end else if (cmd1_v) begin
            o_q_push = 1'b1;
            o_q_cmd  = cmd1;
        end

        // literal store and r_first stay frozen until the back end drains the group
        n_busy = r_busy;
        if (i_lit_done) begin
            n_busy = 1'b0;
        end
        if (o_q_push && o_q_cmd.kind == CMD_LIT) begin
            n_busy = 1'b1;
        end

        o_lit_first = r_first;
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_hold  <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_have       <= 1'b0;
            r_run        <= '0;
            r_lit_len    <= '0;
            r_in_lit     <= 1'b0;
            r_busy       <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_prev       <= n_prev;
            r_have       <= n_have;
            r_run        <= n_run;
            r_lit_len    <= n_lit_len;
            r_in_lit     <= n_in_lit;
            r_busy       <= n_busy;
            r_hold_valid <= n_hold_valid;
        end
    end

    `PBRLE_ASSERT_IMP(a_lit_push_idle, i_clk, i_rst_n, o_q_push && o_q_cmd.kind == CMD_LIT, !r_busy, "literal token queued while another is draining")
    `PBRLE_ASSERT(a_hold_is_run, i_clk, i_rst_n, !r_hold_valid || r_hold.kind == CMD_RUN, "held token is not a repeat token")
    `PBRLE_ASSERT_IMP(a_lit_len_range, i_clk, i_rst_n, r_in_lit, r_lit_len >= LW'(2) && r_lit_len <= LW'(MAX_LITERAL), "literal length out of range")

endmodule

`default_nettype wire

### rtl/pbrle_back.sv
// Back end: expands token commands into result items, drains the literal store.
`default_nettype none
`include "packbits_style_rle_encoder_core_defines.svh"

module pbrle_back #(
    parameter int MAX_LITERAL = 32,
    localparam int IW         = $clog2(MAX_LITERAL)
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  pbrle_pkg::t_cmd                     i_q_cmd,
    input  wire                                 i_q_empty,
    output logic                                o_q_pop,
    input  wire                                 i_wr_en,
    input  wire  [IW-1:0]                       i_wr_addr,
    input  wire  [pbrle_pkg::BYTE_W-1:0]        i_wr_data,
    input  wire  [pbrle_pkg::BYTE_W-1:0]        i_lit_first,
    output logic                                o_lit_done,
    input  wire                                 i_pop,
    output logic                                o_empty,
    output logic                                o_is_count,
    output logic signed [pbrle_pkg::TOK_W-1:0]  o_token_count,
    output logic [pbrle_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                                o_burst_end,
    output logic                                o_stream_end
);
    import pbrle_pkg::*;

    logic [BYTE_W-1:0] r_store [MAX_LITERAL];
    logic [BYTE_W-1:0] r_rd_data;
    t_back_state       r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     rd_addr;
    logic              r_out_valid;
    logic              r_out_is_count;
    logic [TOK_W-1:0]  r_out_count;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_be, r_out_se;
    logic              out_ready, load, finish, take, lit_last;
    logic              ld_is_count, ld_be, ld_se;
    logic [TOK_W-1:0]  ld_count;
    logic [BYTE_W-1:0] ld_byte;

    always_comb begin
        out_ready   = !r_out_valid || i_pop;
        lit_last    = (CNT_W'(r_idx) + CNT_W'(1)) == r_cmd.count;
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        rd_addr     = r_idx;
        load        = 1'b0;
        finish      = 1'b0;
        take        = 1'b0;
        o_lit_done  = 1'b0;
        ld_is_count = 1'b0;
        ld_count    = '0;
        ld_byte     = '0;
        ld_be       = 1'b0;
        ld_se       = 1'b0;

        case (r_state)
            BK_IDLE: begin
                take = !i_q_empty;
            end
            BK_COUNT: begin
                if (out_ready) begin
                    load        = 1'b1;
                    ld_is_count = 1'b1;
                    if (r_cmd.kind == CMD_RUN) begin
                        ld_count = {1'b0, r_cmd.count};
                        n_state  = BK_RUN_BYTE;
                    end else begin
                        ld_count = '0 - {1'b0, r_cmd.count};
                        n_state  = BK_LIT_BYTE;
                    end
                end
            end
            BK_RUN_BYTE: begin
                if (out_ready) begin
                    load    = 1'b1;
                    ld_byte = r_cmd.data;
                    ld_be   = r_cmd.burst_end;
                    ld_se   = r_cmd.stream_end;
                    finish  = 1'b1;
                end
            end
            BK_LIT_BYTE: begin
                if (out_ready) begin
                    load    = 1'b1;
                    // entry 0 of a group is held by the front end
                    ld_byte = (r_idx == '0) ? i_lit_first : r_rd_data;
                    if (lit_last) begin
                        ld_be      = r_cmd.burst_end;
                        ld_se      = r_cmd.stream_end;
                        finish     = 1'b1;
                        o_lit_done = 1'b1;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        rd_addr = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (finish) begin
            n_state = BK_IDLE;
            take    = !i_q_empty;
        end
        if (take) begin
            n_cmd   = i_q_cmd;
            n_idx   = '0;
            n_state = BK_COUNT;
        end
        o_q_pop = take;

        o_empty       = !r_out_valid;
        o_is_count    = r_out_is_count;
        o_token_count = $signed(r_out_count);
        o_out_byte    = r_out_byte;
        o_burst_end   = r_out_be;
        o_stream_end  = r_out_se;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        if (load) begin
            r_out_is_count <= ld_is_count;
            r_out_count    <= ld_count;
            r_out_byte     <= ld_byte;
            r_out_be       <= ld_be;
            r_out_se       <= ld_se;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `PBRLE_ASSERT_IMP(a_lit_state_cmd, i_clk, i_rst_n, r_state == BK_LIT_BYTE, r_cmd.kind == CMD_LIT && r_cmd.count != '0, "literal drain without a literal token")
    `PBRLE_ASSERT_IMP(a_lit_idx_range, i_clk, i_rst_n, r_state == BK_LIT_BYTE, CNT_W'(r_idx) < r_cmd.count, "literal index past group length")
    `PBRLE_ASSERT_IMP(a_count_not_last, i_clk, i_rst_n, r_out_valid && r_out_is_count, !r_out_be && !r_out_se, "count item flagged as last result")

endmodule

`default_nettype wire

### test/tb_packbits_style_rle_encoder_core.sv
// Self-checking testbench for the PackBits-style RLE encoder core.
module tb_packbits_style_rle_encoder_core;
    import pbrle_pkg::*;

    localparam int MAX_LIT = 32;
    localparam int MAX_REP = 255;

    typedef enum logic {
        SEQ_REPEAT,
        SEQ_RAMP
    } t_seq_kind;

    // one directed row: a repeated byte or an ascending ramp, final flag on its last byte;
    // when hand_typed is set, the last byte must yield exactly one repeat token
    typedef struct packed {
        t_seq_kind          kind;
        logic [BYTE_W-1:0]  first;
        logic [8:0]         len;
        logic               fin;
        logic               hand_typed;
        logic [TOK_W-1:0]   t_count;
        logic [BYTE_W-1:0]  t_byte;
        logic               t_stream;
    } t_dir_row;

    typedef struct {
        logic               is_count;
        logic [TOK_W-1:0]   count;
        logic [BYTE_W-1:0]  data;
        logic               burst_end;
        logic               stream_end;
    } t_token_item;

    localparam int N_ROWS = 19;
    localparam t_dir_row DIRECTED_ROWS [0:N_ROWS-1] = '{
        '{SEQ_REPEAT, 8'h00, 9'd1,   1'b1, 1'b1, 9'd1,   8'h00, 1'b1},
        '{SEQ_REPEAT, 8'hFF, 9'd1,   1'b1, 1'b1, 9'd1,   8'hFF, 1'b1},
        '{SEQ_REPEAT, 8'hAA, 9'd3,   1'b0, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'h55, 9'd1,   1'b0, 1'b1, 9'd3,   8'hAA, 1'b0},
        '{SEQ_REPEAT, 8'h55, 9'd1,   1'b1, 1'b1, 9'd2,   8'h55, 1'b1},
        '{SEQ_RAMP,   8'h01, 9'd3,   1'b0, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'h03, 9'd1,   1'b0, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'h80, 9'd1,   1'b1, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_RAMP,   8'h7E, 9'd3,   1'b1, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_RAMP,   8'h10, 9'd34,  1'b0, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'h31, 9'd1,   1'b1, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'h5A, 9'd256, 1'b0, 1'b1, 9'd255, 8'h5A, 1'b0},
        '{SEQ_REPEAT, 8'h5A, 9'd1,   1'b1, 1'b1, 9'd2,   8'h5A, 1'b1},
        '{SEQ_RAMP,   8'hC0, 9'd2,   1'b1, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_RAMP,   8'h40, 9'd2,   1'b0, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'h41, 9'd2,   1'b1, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_RAMP,   8'h20, 9'd32,  1'b1, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'h00, 9'd2,   1'b0, 1'b0, 9'd0,   8'h00, 1'b0},
        '{SEQ_REPEAT, 8'hFF, 9'd1,   1'b1, 1'b0, 9'd0,   8'h00, 1'b0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    logic [BYTE_W-1:0]      i_data_byte;
    logic                   i_final_byte;
    logic                   empty;
    logic                   pop;
    logic                   o_is_count;
    logic signed [TOK_W-1:0] o_token_count;
    logic [BYTE_W-1:0]      o_out_byte;
    logic                   o_burst_end;
    logic                   o_stream_end;

    // encoder state mirror
    logic [BYTE_W-1:0]  last_byte;
    bit                 string_open;
    int                 run_count;
    logic [BYTE_W-1:0]  lit_buf [0:MAX_LIT-1];
    int                 lit_count;
    bit                 lit_mode;

    t_token_item        step_items[$];
    t_token_item        expected_tokens[$];
    t_token_item        head_item;
    int                 mismatch_count = 0;
    bit                 idle_on = 1'b1;

    packbits_style_rle_encoder_core #(
        .MAX_LITERAL(MAX_LIT),
        .MAX_RUN    (MAX_REP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .empty        (empty),
        .pop          (pop),
        .o_is_count   (o_is_count),
        .o_token_count(o_token_count),
        .o_out_byte   (o_out_byte),
        .o_burst_end  (o_burst_end),
        .o_stream_end (o_stream_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void add_repeat(input int len, input logic [BYTE_W-1:0] b);
        step_items.push_back('{1'b1, TOK_W'(len), 8'h00, 1'b0, 1'b0});
        step_items.push_back('{1'b0, 9'd0, b, 1'b0, 1'b0});
    endfunction

    function automatic void add_literal(input int n);
        int k;
        step_items.push_back('{1'b1, TOK_W'(-n), 8'h00, 1'b0, 1'b0});
        for (k = 0; k < n; k++) begin
            step_items.push_back('{1'b0, 9'd0, lit_buf[k], 1'b0, 1'b0});
        end
    endfunction

    // advance the state mirror by one byte and queue the tokens it completes
    function automatic void encode_byte(input logic [BYTE_W-1:0] b, input bit fin);
        t_token_item tail;
        step_items.delete();
        if (!string_open) begin
            string_open = 1'b1;
            lit_mode    = 1'b0;
            run_count   = 1;
            lit_count   = 0;
        end else if (!lit_mode) begin
            if (b == last_byte) begin
                if (run_count >= MAX_REP) begin
                    add_repeat(MAX_REP, last_byte);
                    run_count = 1;
                end else begin
                    run_count++;
                end
            end else if (run_count >= 2) begin
                add_repeat(run_count, last_byte);
                run_count = 1;
            end else begin
                lit_buf[0] = last_byte;
                lit_buf[1] = b;
                lit_count  = 2;
                lit_mode   = 1'b1;
                run_count  = 0;
            end
        end else begin
            if (b == last_byte) begin
                // repeated tail byte leaves the group and seeds a run of two
                add_literal(lit_count - 1);
                lit_mode  = 1'b0;
                lit_count = 0;
                run_count = 2;
            end else if (lit_count >= MAX_LIT) begin
                add_literal(lit_count);
                lit_mode  = 1'b0;
                lit_count = 0;
                run_count = 1;
            end else begin
                lit_buf[lit_count] = b;
                lit_count++;
            end
        end
        last_byte = b;

        if (fin) begin
            if (lit_mode) add_literal(lit_count);
            else          add_repeat(run_count, last_byte);
            last_byte   = '0;
            string_open = 1'b0;
            run_count   = 0;
            lit_count   = 0;
            lit_mode    = 1'b0;
        end

        if (step_items.size() > 0) begin
            tail            = step_items.pop_back();
            tail.burst_end  = 1'b1;
            tail.stream_end = fin;
            step_items.push_back(tail);
        end
        foreach (step_items[k]) expected_tokens.push_back(step_items[k]);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit fin, input bit hand_typed,
                             input logic [TOK_W-1:0] t_count, input logic [BYTE_W-1:0] t_byte,
                             input bit t_stream);
        int n0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (full);
        n0 = expected_tokens.size();
        encode_byte(b, fin);
        if (hand_typed) begin
            while (expected_tokens.size() > n0) void'(expected_tokens.pop_back());
            expected_tokens.push_back('{1'b1, t_count, 8'h00, 1'b0, 1'b0});
            expected_tokens.push_back('{1'b0, 9'd0, t_byte, 1'b1, t_stream});
        end
    endtask

    // hold the sender off until every queued token has come out
    task automatic drain_tokens();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
            mismatch_count++;
        end
    endtask

    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual count %0d byte %0d",
                         $time, o_token_count, o_out_byte);
                mismatch_count++;
            end else begin
                head_item = expected_tokens.pop_front();
                compare_field("is_count", int'(head_item.is_count), int'(o_is_count));
                compare_field("token_count", int'($signed(head_item.count)),
                              int'(o_token_count));
                compare_field("out_byte", int'(head_item.data), int'(o_out_byte));
                compare_field("burst_end", int'(head_item.burst_end), int'(o_burst_end));
                compare_field("stream_end", int'(head_item.stream_end), int'(o_stream_end));
            end
        end
    end

    initial begin
        int                 r;
        int                 i;
        int                 seg;
        int                 nseg;
        int                 seg_len;
        int                 rand_items;
        bit                 paused;
        logic [BYTE_W-1:0]  b;
        logic [BYTE_W-1:0]  str_bytes[$];

        push         <= 1'b0;
        i_data_byte  <= '0;
        i_final_byte <= 1'b0;
        i_rst_n      <= 1'b0;
        last_byte    = '0;
        string_open  = 1'b0;
        run_count    = 0;
        lit_count    = 0;
        lit_mode     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_ROWS; r++) begin
            for (i = 0; i < DIRECTED_ROWS[r].len; i++) begin
                b = (DIRECTED_ROWS[r].kind == SEQ_RAMP) ? DIRECTED_ROWS[r].first + BYTE_W'(i)
                                                        : DIRECTED_ROWS[r].first;
                send_byte(b, DIRECTED_ROWS[r].fin && (i == DIRECTED_ROWS[r].len - 1),
                          DIRECTED_ROWS[r].hand_typed && (i == DIRECTED_ROWS[r].len - 1),
                          DIRECTED_ROWS[r].t_count, DIRECTED_ROWS[r].t_byte,
                          DIRECTED_ROWS[r].t_stream);
            end
        end
        drain_tokens();

        rand_items = 0;
        paused     = 1'b0;
        while (rand_items < 170) begin
            // quiet stretches mixed in, and none at all near the end
            idle_on = (rand_items < 130) && ($urandom_range(0, 3) != 0);
            str_bytes.delete();
            if ($urandom_range(0, 7) == 0) begin
                str_bytes.push_back(BYTE_W'($urandom));
                send_byte(str_bytes[0], $urandom_range(0, 3) == 0, 1'b0, '0, '0, 1'b0);
                rand_items++;
            end else begin
                nseg = $urandom_range(1, 5);
                for (seg = 0; seg < nseg; seg++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        seg_len = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 260)
                                                               : $urandom_range(1, 6);
                        b = BYTE_W'($urandom);
                        if ($urandom_range(0, 1) == 1) b = {4{b[1:0]}};
                        repeat (seg_len) str_bytes.push_back(b);
                    end else begin
                        seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                              : $urandom_range(2, 8);
                        repeat (seg_len) begin
                            b = BYTE_W'($urandom);
                            if ($urandom_range(0, 1) == 1) b = {4{b[1:0]}};
                            if (str_bytes.size() > 0 && b == str_bytes[$]) b = b + BYTE_W'(1);
                            str_bytes.push_back(b);
                        end
                    end
                end
                for (i = 0; i < str_bytes.size(); i++) begin
                    send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0, '0, 1'b0);
                end
                rand_items += str_bytes.size();
            end
            if (!paused && rand_items >= 85) begin
                drain_tokens();
                paused = 1'b1;
            end
        end

        push <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
